[hw/rtl/stir_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stir_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] key_value;
        logic [3:0]  entry_index;
    } request_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [4:0]  entry_total;
        status_t     status;
    } result_t;

    // per-cell control, computed for each cell by the top level every cycle
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic at_count;
        logic below_count;
        logic from_idx;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/sorted_table_insert_remove_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sorted key table: a row of cells, one per slot, kept in ascending order.
// Request channel: request is taken at a rising edge with start high and
// busy low. busy is always low; a new request may be issued every cycle.
// Commands: insert key (ahead of equal keys), lookup by index, remove by
// index. Insert into a full table and lookup/remove past the count are
// flagged in status and leave the table unchanged.
// Result channel: exactly one result per request, on result for the single
// cycle in which done is high, the cycle after the request is taken.
// Throughput is 1 request per cycle: every cell compares its own entry
// against the key and shifts to its neighbor in the same cycle, so no
// command needs more than one pass through the row.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Reset clears all entries and the count to zero, and drops done.

module sorted_table_insert_remove_core
    import stir_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
)
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 done_reg;
    result_t              result_reg;
    result_t              result_next;

    logic [KEY_WIDTH-1:0] key;
    logic [CMPW-1:0]      count_w;
    logic [CMPW-1:0]      idx_w;
    logic                 accept;
    logic                 full;
    logic                 in_range;
    logic                 ins_ok;
    logic                 rem_ok;
    logic [KEY_WIDTH-1:0] lookup_word;
    logic [31:0]          lookup_value;

    cell_ctrl_t           ctrl [DEPTH];
    logic [KEY_WIDTH-1:0] ent  [DEPTH];
    logic                 place [DEPTH];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign count_w = CMPW'(count_reg);
    assign idx_w   = CMPW'(request.entry_index);
    assign full    = (count_reg == CW'(DEPTH));
    assign in_range = (idx_w < count_w);
    assign ins_ok  = accept && (request.command == CMD_INSERT) && !full;
    assign rem_ok  = accept && (request.command == CMD_REMOVE) && in_range;

    generate
        if (KEY_WIDTH <= 32)
        begin : g_key_narrow
            assign key = request.key_value[KEY_WIDTH-1:0];
            assign lookup_value = 32'(lookup_word);
        end
        else
        begin : g_key_wide
            assign key = KEY_WIDTH'(request.key_value);
            assign lookup_value = lookup_word[31:0];
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                 place_in;
            logic [KEY_WIDTH-1:0] lower_entry;
            logic [KEY_WIDTH-1:0] upper_entry;

            assign ctrl[gi].do_insert   = ins_ok;
            assign ctrl[gi].do_remove   = rem_ok;
            assign ctrl[gi].at_count    = (CMPW'(gi) == count_w);
            assign ctrl[gi].below_count = (CMPW'(gi) < count_w);
            assign ctrl[gi].from_idx    = (CMPW'(gi) >= idx_w);

            if (gi == 0)
            begin : g_bottom
                assign place_in    = 1'b0;
                assign lower_entry = '0;
            end
            else
            begin : g_mid_lo
                assign place_in    = place[gi-1];
                assign lower_entry = ent[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_top
                assign upper_entry = '0;
            end
            else
            begin : g_mid_hi
                assign upper_entry = ent[gi+1];
            end

            stir_cell #(
                .KEY_WIDTH(KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[gi]),
                .key        (key),
                .place_in   (place_in),
                .lower_entry(lower_entry),
                .upper_entry(upper_entry),
                .place_out  (place[gi]),
                .entry      (ent[gi])
            );
        end
    endgenerate

    // and-or select of the addressed cell
    always_comb
    begin
        lookup_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CMPW'(i) == idx_w)
                lookup_word = lookup_word | ent[i];
        end
    end

    always_comb
    begin
        count_next              = count_reg;
        result_next.read_value  = '0;
        result_next.status      = ST_DONE;
        case (request.command)
            CMD_INSERT:
            begin
                if (full)
                    result_next.status = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            CMD_LOOKUP:
            begin
                if (in_range)
                    result_next.read_value = lookup_value;
                else
                    result_next.status = ST_RANGE;
            end
            CMD_REMOVE:
            begin
                if (in_range)
                    count_next = count_reg - 1'b1;
                else
                    result_next.status = ST_RANGE;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result_next.entry_total = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("request did not produce a result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> (result.entry_total == 5'(DEPTH)))
        else $error("full status with table not full");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_RANGE) |-> (result.read_value == '0))
        else $error("nonzero read value on range error");

endmodule

`default_nettype wire

[hw/rtl/stir_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module stir_cell
    import stir_pkg::*;
#(
    parameter int KEY_WIDTH = 32
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire cell_ctrl_t      ctrl,
    input  wire [KEY_WIDTH-1:0]  key,
    input  wire                  place_in,
    input  wire [KEY_WIDTH-1:0]  lower_entry,
    input  wire [KEY_WIDTH-1:0]  upper_entry,
    output logic                 place_out,
    output logic [KEY_WIDTH-1:0] entry
);

    logic [KEY_WIDTH-1:0] entry_reg;
    logic [KEY_WIDTH-1:0] entry_next;

    // high on slots holding a key not less than the new one and on the first free slot; the lowest takes the key
    assign place_out = (ctrl.below_count && (entry_reg >= key)) || ctrl.at_count;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_insert)
        begin
            if (place_in)
                entry_next = lower_entry;
            else if (place_out)
                entry_next = key;
        end
        else if (ctrl.do_remove)
        begin
            if (ctrl.from_idx)
                entry_next = upper_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

endmodule

`default_nettype wire
